/* rtl/core/rect_hit_test_activation_unit_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the rect hit test activation unit
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef RECT_HIT_TEST_ACTIVATION_UNIT_ASSERT_SVH
`define RECT_HIT_TEST_ACTIVATION_UNIT_ASSERT_SVH

// Same-cycle implication.
`define RHT_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define RHT_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/rht_pkg.sv */
// ----------------------------------------------------------------------------
// rht_pkg
// Shared constants, types and the containment function of the hit tester.
// ----------------------------------------------------------------------------
package rht_pkg;

  localparam int REGIONS = 64;
  localparam int IDX_W   = (REGIONS > 1) ? $clog2(REGIONS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(REGIONS - 1);

  // Transaction opcodes
  localparam logic [1:0] OP_LOAD_RECT = 2'd0;
  localparam logic [1:0] OP_LOAD_CLIP = 2'd1;
  localparam logic [1:0] OP_POINTER   = 2'd2;
  localparam logic [1:0] OP_CLEAR     = 2'd3;

  typedef struct packed {
    logic        [14:0] h;
    logic        [14:0] w;
    logic signed [15:0] y;
    logic signed [15:0] x;
  } rect_t;

  typedef struct packed {
    rect_t              rect;
    logic signed [15:0] layer;
    logic        [7:0]  tag;
  } region_t;

  // Controller to datapath commands
  typedef struct packed {
    logic             wr_rect;
    logic             wr_clip;
    logic             clear;
    logic             capture;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             finish;
    logic             ack_load;
  } dp_cmd_t;

  // x <= px < x+w and y <= py < y+h, sums at 17 bits
  function automatic logic rect_contains(rect_t r, logic signed [15:0] px,
                                         logic signed [15:0] py);
    logic signed [16:0] x_lo;
    logic signed [16:0] y_lo;
    logic signed [16:0] x_hi;
    logic signed [16:0] y_hi;
    logic signed [16:0] px_e;
    logic signed [16:0] py_e;
    x_lo = {r.x[15], r.x};
    y_lo = {r.y[15], r.y};
    x_hi = x_lo + $signed({2'b00, r.w});
    y_hi = y_lo + $signed({2'b00, r.h});
    px_e = {px[15], px};
    py_e = {py[15], py};
    return (px_e >= x_lo) && (px_e < x_hi) && (py_e >= y_lo) && (py_e < y_hi);
  endfunction

endpackage

/* rtl/core/rht_ctrl.sv */
// ----------------------------------------------------------------------------
// rht_ctrl
// Sequencer: decodes transactions, walks the table scan, triggers the result.
// ----------------------------------------------------------------------------
module rht_ctrl import rht_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [1:0] in_op,
  output logic       busy,
  output dp_cmd_t    cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic             drain_r, drain_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    drain_nxt = drain_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          case (in_op)
            OP_LOAD_RECT: begin
              cmd.wr_rect  = 1'b1;
              cmd.ack_load = 1'b1;
            end
            OP_LOAD_CLIP: begin
              cmd.wr_clip  = 1'b1;
              cmd.ack_load = 1'b1;
            end
            OP_CLEAR: begin
              cmd.clear    = 1'b1;
              cmd.ack_load = 1'b1;
            end
            OP_POINTER: begin
              cmd.capture = 1'b1;
              cnt_nxt     = '0;
              state_nxt   = ST_SCAN;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_addr = cnt_r;
        if (cnt_r == LAST_IDX) begin
          drain_nxt = 1'b0;
          state_nxt = ST_DRAIN;
        end else begin
          cnt_nxt = cnt_r + IDX_W'(1);
        end
      end
      ST_DRAIN: begin
        // wait for the read and compare stages to empty
        drain_nxt = 1'b1;
        if (drain_r) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        cmd.finish = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      drain_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      drain_r <= drain_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule

/* rtl/core/rht_dp.sv */
// ----------------------------------------------------------------------------
// rht_dp
// Region tables, scan pipeline, best-hit tracking, press latch, result regs.
// ----------------------------------------------------------------------------
module rht_dp import rht_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  dp_cmd_t            cmd,
  input  logic        [5:0]  in_slot,
  input  logic signed [15:0] in_pos_x,
  input  logic signed [15:0] in_pos_y,
  input  logic        [14:0] in_size_w,
  input  logic        [14:0] in_size_h,
  input  logic signed [15:0] in_layer_in,
  input  logic               in_clip_on,
  input  logic        [7:0]  in_tag_in,
  input  logic               in_pressed,
  input  logic               in_held,
  input  logic               in_released,
  output logic               out_valid,
  output logic               out_hit_valid,
  output logic        [5:0]  out_hit_slot,
  output logic               out_active_valid,
  output logic        [5:0]  out_active_slot,
  output logic               out_activated,
  output logic        [5:0]  out_activated_slot,
  output logic        [7:0]  out_activated_tag
);

  // Table storage
  region_t          main_mem [REGIONS];
  rect_t            clip_mem [REGIONS];
  logic [REGIONS-1:0] valid_r;
  logic [REGIONS-1:0] has_clip_r;

  logic             slot_ok;
  logic [IDX_W-1:0] wr_addr;
  rect_t            load_rect;

  assign slot_ok   = (32'(in_slot) < REGIONS);
  assign wr_addr   = IDX_W'(in_slot);
  assign load_rect = '{h: in_size_h, w: in_size_w, y: in_pos_y, x: in_pos_x};

  // Pointer event operands
  logic signed [15:0] px_r, py_r;
  logic               pressed_r, held_r, released_r;

  // Stage 1: registered table read
  region_t          main_rd_r;
  rect_t            clip_rd_r;
  logic             s1_vld_r;
  logic [IDX_W-1:0] s1_idx_r;
  logic             s1_valid_r, s1_has_clip_r;

  // Stage 2: containment result
  logic               s2_hit_r;
  logic signed [15:0] s2_layer_r;
  logic        [7:0]  s2_tag_r;
  logic [IDX_W-1:0]   s2_idx_r;

  // Stage 3: running best
  logic               best_hit_r;
  logic signed [15:0] best_layer_r;
  logic        [7:0]  best_tag_r;
  logic [IDX_W-1:0]   best_idx_r;

  // Press latch
  logic             latch_vld_r;
  logic [IDX_W-1:0] latch_slot_r;

  logic in_rect, in_clip;
  logic s2_hit_nxt;

  always_ff @(posedge clk) begin
    if (cmd.wr_rect && slot_ok) begin
      main_mem[wr_addr] <= '{rect: load_rect, layer: in_layer_in, tag: in_tag_in};
    end
    if (cmd.rd_en) begin
      main_rd_r <= main_mem[cmd.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_clip && slot_ok) begin
      clip_mem[wr_addr] <= load_rect;
    end
    if (cmd.rd_en) begin
      clip_rd_r <= clip_mem[cmd.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      has_clip_r <= '0;
    end else if (cmd.clear) begin
      valid_r    <= '0;
      has_clip_r <= '0;
    end else if (cmd.wr_rect && slot_ok) begin
      valid_r[wr_addr]    <= 1'b1;
      has_clip_r[wr_addr] <= in_clip_on;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      px_r       <= in_pos_x;
      py_r       <= in_pos_y;
      pressed_r  <= in_pressed;
      held_r     <= in_held;
      released_r <= in_released;
    end
  end

  // Stage 1 side info
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= cmd.rd_en;
    end
    if (cmd.rd_en) begin
      s1_idx_r      <= cmd.rd_addr;
      s1_valid_r    <= valid_r[cmd.rd_addr];
      s1_has_clip_r <= has_clip_r[cmd.rd_addr];
    end
  end

  // Stage 2
  assign in_rect    = rect_contains(main_rd_r.rect, px_r, py_r);
  assign in_clip    = rect_contains(clip_rd_r, px_r, py_r);
  assign s2_hit_nxt = s1_vld_r && s1_valid_r && in_rect && (!s1_has_clip_r || in_clip);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_hit_r <= 1'b0;
    end else begin
      s2_hit_r <= s2_hit_nxt;
    end
    s2_layer_r <= main_rd_r.layer;
    s2_tag_r   <= main_rd_r.tag;
    s2_idx_r   <= s1_idx_r;
  end

  // Stage 3: ascending scan with >= hands ties to the higher slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_hit_r <= 1'b0;
    end else if (cmd.capture) begin
      best_hit_r <= 1'b0;
    end else if (s2_hit_r && (!best_hit_r || (s2_layer_r >= best_layer_r))) begin
      best_hit_r <= 1'b1;
    end
    if (s2_hit_r && (!best_hit_r || (s2_layer_r >= best_layer_r))) begin
      best_layer_r <= s2_layer_r;
      best_tag_r   <= s2_tag_r;
      best_idx_r   <= s2_idx_r;
    end
  end

  // Result evaluation
  logic [IDX_W-1:0] hslot;
  logic             lv_p;
  logic [IDX_W-1:0] ls_p;
  logic             act;

  always_comb begin
    hslot = best_hit_r ? best_idx_r : '0;
    lv_p  = pressed_r ? best_hit_r : latch_vld_r;
    ls_p  = pressed_r ? hslot : latch_slot_r;
    act   = released_r && best_hit_r && lv_p && (hslot == ls_p);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latch_vld_r  <= 1'b0;
      latch_slot_r <= '0;
    end else if (cmd.clear) begin
      latch_vld_r  <= 1'b0;
      latch_slot_r <= '0;
    end else if (cmd.finish) begin
      latch_vld_r  <= released_r ? 1'b0 : lv_p;
      latch_slot_r <= released_r ? '0 : ls_p;
    end
  end

  logic       out_valid_r;
  logic       hit_valid_r, active_valid_r, activated_r;
  logic [5:0] hit_slot_r, active_slot_r, activated_slot_r;
  logic [7:0] activated_tag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.finish || cmd.ack_load;
    end
    if (cmd.ack_load) begin
      hit_valid_r      <= 1'b0;
      hit_slot_r       <= '0;
      active_valid_r   <= 1'b0;
      active_slot_r    <= '0;
      activated_r      <= 1'b0;
      activated_slot_r <= '0;
      activated_tag_r  <= '0;
    end else if (cmd.finish) begin
      hit_valid_r      <= best_hit_r;
      hit_slot_r       <= 6'(hslot);
      active_valid_r   <= lv_p && held_r;
      active_slot_r    <= 6'(ls_p);
      activated_r      <= act;
      activated_slot_r <= act ? 6'(hslot) : 6'd0;
      activated_tag_r  <= act ? best_tag_r : 8'd0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_hit_valid      = hit_valid_r;
  assign out_hit_slot       = hit_slot_r;
  assign out_active_valid   = active_valid_r;
  assign out_active_slot    = active_slot_r;
  assign out_activated      = activated_r;
  assign out_activated_slot = activated_slot_r;
  assign out_activated_tag  = activated_tag_r;

endmodule

/* rtl/core/rect_hit_test_activation_unit.sv */
// ----------------------------------------------------------------------------
// rect_hit_test_activation_unit
// Priority rectangle hit test over a region table with press/release
// activation.
// ----------------------------------------------------------------------------
// Usage: a transaction is taken when start is high and busy is low. Every
// transaction returns exactly one result, shown for a single cycle while
// out_valid is high; there is no backpressure, so the receiver must sample
// every out_valid cycle. Table loads (rectangle, clip) and table clear
// leave busy low, so they may be issued back to back; their result (all
// fields zero) appears the cycle after acceptance. A pointer event scans
// the whole table, one entry per cycle through the single read port of
// the table memories, then drains the scan pipeline before its result
// strobe; busy stays high until the strobe cycle. No clearing pass is
// needed after reset: valid and clip enable bits are flops cleared by
// reset or by a clear transaction.
// ----------------------------------------------------------------------------
//
// Structure:
//   rht_ctrl - sequencer: opcode decode, scan address counter, drain, finish
//   rht_dp   - table memories, 3-stage scan pipeline (read, contain, best),
//              press latch and registered result
//
// Priority: highest signed layer wins; on equal layers the higher slot wins
// because the scan runs in ascending order and a tie replaces the best.
// A press latches the hit slot; a release over the latched slot reports an
// activation with the region's tag. Any release drops the latch.

module rect_hit_test_activation_unit import rht_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,

  input  logic               start,
  output logic               busy,
  input  logic        [1:0]  in_op,
  input  logic        [5:0]  in_slot,
  input  logic signed [15:0] in_pos_x,
  input  logic signed [15:0] in_pos_y,
  input  logic        [14:0] in_size_w,
  input  logic        [14:0] in_size_h,
  input  logic signed [15:0] in_layer_in,
  input  logic               in_clip_on,
  input  logic        [7:0]  in_tag_in,
  input  logic               in_pressed,
  input  logic               in_held,
  input  logic               in_released,

  output logic               out_valid,
  output logic               out_hit_valid,
  output logic        [5:0]  out_hit_slot,
  output logic               out_active_valid,
  output logic        [5:0]  out_active_slot,
  output logic               out_activated,
  output logic        [5:0]  out_activated_slot,
  output logic        [7:0]  out_activated_tag
);

  dp_cmd_t cmd;

  rht_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .in_op (in_op),
    .busy  (busy),
    .cmd   (cmd)
  );

  rht_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .in_slot            (in_slot),
    .in_pos_x           (in_pos_x),
    .in_pos_y           (in_pos_y),
    .in_size_w          (in_size_w),
    .in_size_h          (in_size_h),
    .in_layer_in        (in_layer_in),
    .in_clip_on         (in_clip_on),
    .in_tag_in          (in_tag_in),
    .in_pressed         (in_pressed),
    .in_held            (in_held),
    .in_released        (in_released),
    .out_valid          (out_valid),
    .out_hit_valid      (out_hit_valid),
    .out_hit_slot       (out_hit_slot),
    .out_active_valid   (out_active_valid),
    .out_active_slot    (out_active_slot),
    .out_activated      (out_activated),
    .out_activated_slot (out_activated_slot),
    .out_activated_tag  (out_activated_tag)
  );

endmodule

/* rtl/core/rht_checker.sv */
// ----------------------------------------------------------------------------
// rht_checker
// Port-level checks of the hit test unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "rect_hit_test_activation_unit_assert.svh"

module rht_checker import rht_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic [1:0]  in_op,
  input logic        out_valid,
  input logic        out_hit_valid,
  input logic [5:0]  out_hit_slot,
  input logic        out_activated,
  input logic [5:0]  out_activated_slot
);

  // activation only over a hit region, and on that same slot
  `RHT_ASSERT_NOW(a_act_needs_hit, out_valid && out_activated, out_hit_valid, "activation without hit")
  `RHT_ASSERT_NOW(a_act_slot, out_valid && out_activated, out_activated_slot == out_hit_slot, "activated slot differs from hit slot")
  // no hit reports slot zero
  `RHT_ASSERT_NOW(a_miss_slot, out_valid && !out_hit_valid, out_hit_slot == 6'd0, "hit slot set on miss")
  // a pointer transaction starts a scan
  `RHT_ASSERT_NEXT(a_scan_busy, start && !busy && (in_op == OP_POINTER), busy, "pointer event did not start scan")
  // table transactions answer on the next cycle
  `RHT_ASSERT_NEXT(a_load_ack, start && !busy && (in_op != OP_POINTER), out_valid && !busy, "table transaction not acknowledged")

endmodule

bind rect_hit_test_activation_unit rht_checker u_rht_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .start              (start),
  .busy               (busy),
  .in_op              (in_op),
  .out_valid          (out_valid),
  .out_hit_valid      (out_hit_valid),
  .out_hit_slot       (out_hit_slot),
  .out_activated      (out_activated),
  .out_activated_slot (out_activated_slot)
);

/* verif/tb_rect_hit_test_activation_unit.sv */
// ----------------------------------------------------------------------------
// tb_rect_hit_test_activation_unit
// Self-checking bench for the priority rectangle hit tester. A short table
// of directed transactions covers the extreme coordinates, every opcode,
// layer ties, clipping, zero-size regions and the press/release latch.
// Random press/hold/release gestures over a randomly loaded table follow,
// mixed with table loads, clears and noise. A built-in model of the region
// table predicts every result but the typed directed ones; results are compared field by field.
// ----------------------------------------------------------------------------
module tb_rect_hit_test_activation_unit;
  import rht_pkg::*;

  localparam int RANDOM_ITEMS = 625;
  // no acceptance on either side for this long means the DUT is stuck
  localparam int STALL_LIMIT  = 1000;
  // margin beyond a pointer scan for stray strobes at the end
  localparam int SETTLE_CYCLES = REGIONS + 8;

  // One input transaction, field by field at port widths
  typedef struct packed {
    logic        [1:0]  op;
    logic        [5:0]  slot;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic        [14:0] size_w;
    logic        [14:0] size_h;
    logic signed [15:0] layer_in;
    logic               clip_on;
    logic        [7:0]  tag_in;
    logic               pressed;
    logic               held;
    logic               released;
  } hit_cmd_t;

  // One result transaction
  typedef struct packed {
    logic       hit_valid;
    logic [5:0] hit_slot;
    logic       active_valid;
    logic [5:0] active_slot;
    logic       activated;
    logic [5:0] activated_slot;
    logic [7:0] activated_tag;
  } hit_outcome_t;

  localparam hit_outcome_t NO_OUTCOME = '0;

  // Where a directed row takes its expected result from
  typedef enum bit {PREDICTED, TYPED} want_src_t;

  typedef struct {
    hit_cmd_t     cmd;
    want_src_t    src;
    hit_outcome_t want;
  } script_row_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // DUT inputs, all known from time zero
  logic               start       = 1'b0;
  logic        [1:0]  in_op       = OP_LOAD_RECT;
  logic        [5:0]  in_slot     = '0;
  logic signed [15:0] in_pos_x    = '0;
  logic signed [15:0] in_pos_y    = '0;
  logic        [14:0] in_size_w   = '0;
  logic        [14:0] in_size_h   = '0;
  logic signed [15:0] in_layer_in = '0;
  logic               in_clip_on  = 1'b0;
  logic        [7:0]  in_tag_in   = '0;
  logic               in_pressed  = 1'b0;
  logic               in_held     = 1'b0;
  logic               in_released = 1'b0;

  logic               busy;
  logic               out_valid;
  logic               out_hit_valid;
  logic        [5:0]  out_hit_slot;
  logic               out_active_valid;
  logic        [5:0]  out_active_slot;
  logic               out_activated;
  logic        [5:0]  out_activated_slot;
  logic        [7:0]  out_activated_tag;

  // Shadow region table and press latch
  rect_t              box_of      [REGIONS];
  rect_t              clip_of     [REGIONS];
  logic signed [15:0] layer_of    [REGIONS];
  logic        [7:0]  tag_of      [REGIONS];
  bit                 clip_en     [REGIONS];
  bit                 live        [REGIONS];
  // clip contents survive a clear, so this is only reset at power-up
  bit                 clip_written[REGIONS];
  logic        [5:0]  pressed_slot = '0;
  bit                 pressed_live;

  // Expected results, oldest first
  hit_outcome_t expected_outcomes[$];

  int  sent_items;
  int  mismatch_count;
  int  pointer_count;
  int  clear_count;
  int  hit_count;
  int  activation_count;
  bit  steady;          // sender gaps suppressed

  rect_hit_test_activation_unit dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_op              (in_op),
    .in_slot            (in_slot),
    .in_pos_x           (in_pos_x),
    .in_pos_y           (in_pos_y),
    .in_size_w          (in_size_w),
    .in_size_h          (in_size_h),
    .in_layer_in        (in_layer_in),
    .in_clip_on         (in_clip_on),
    .in_tag_in          (in_tag_in),
    .in_pressed         (in_pressed),
    .in_held            (in_held),
    .in_released        (in_released),
    .out_valid          (out_valid),
    .out_hit_valid      (out_hit_valid),
    .out_hit_slot       (out_hit_slot),
    .out_active_valid   (out_active_valid),
    .out_active_slot    (out_active_slot),
    .out_activated      (out_activated),
    .out_activated_slot (out_activated_slot),
    .out_activated_tag  (out_activated_tag)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Region model
  // --------------------------------------------------------------------------

  // Half-open containment: x <= px < x+w, y <= py < y+h, all in int so the
  // upper bound cannot wrap and a zero size contains nothing.
  function automatic bit covers(rect_t r, int px, int py);
    int x0, y0, w0, h0;
    x0 = $signed(r.x);
    y0 = $signed(r.y);
    w0 = r.w;
    h0 = r.h;
    return px >= x0 && px < x0 + w0 && py >= y0 && py < y0 + h0;
  endfunction

  // Applies one accepted transaction to the shadow table and returns the
  // result the DUT must produce for it.
  function automatic hit_outcome_t predict_outcome(hit_cmd_t c);
    hit_outcome_t res;
    rect_t        area;
    bit           found;
    int           best_layer, best_slot, px, py;
    res        = NO_OUTCOME;
    found      = 1'b0;
    best_layer = 0;
    best_slot  = 0;
    area.x = c.pos_x;
    area.y = c.pos_y;
    area.w = c.size_w;
    area.h = c.size_h;
    case (c.op)
      OP_LOAD_RECT: begin
        box_of[c.slot]   = area;
        layer_of[c.slot] = c.layer_in;
        tag_of[c.slot]   = c.tag_in;
        clip_en[c.slot]  = c.clip_on;
        live[c.slot]     = 1'b1;
      end
      OP_LOAD_CLIP: begin
        clip_of[c.slot]      = area;
        clip_written[c.slot] = 1'b1;
      end
      OP_CLEAR: begin
        foreach (live[i]) begin
          live[i]    = 1'b0;
          clip_en[i] = 1'b0;
        end
        pressed_live = 1'b0;
        pressed_slot = '0;
        clear_count++;
      end
      default: begin
        pointer_count++;
        px = $signed(c.pos_x);
        py = $signed(c.pos_y);
        // ascending scan, ">=" lets a later slot win a layer tie
        for (int i = 0; i < REGIONS; i++) begin
          if (live[i] && covers(box_of[i], px, py) &&
              (!clip_en[i] || covers(clip_of[i], px, py)) &&
              (!found || layer_of[i] >= best_layer)) begin
            found      = 1'b1;
            best_layer = layer_of[i];
            best_slot  = i;
          end
        end
        if (c.pressed) begin
          pressed_live = found;
          pressed_slot = found ? 6'(best_slot) : '0;
        end
        // active status is taken after the press and before the release
        res.active_valid = pressed_live && c.held;
        res.active_slot  = pressed_slot;
        if (c.released) begin
          res.activated = found && pressed_live && 6'(best_slot) == pressed_slot;
          pressed_live  = 1'b0;
          pressed_slot  = '0;
        end
        res.hit_valid = found;
        res.hit_slot  = 6'(best_slot);
        if (res.activated) begin
          res.activated_slot = 6'(best_slot);
          res.activated_tag  = tag_of[best_slot];
        end
      end
    endcase
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Transaction builders
  // --------------------------------------------------------------------------

  function automatic hit_cmd_t load_row(logic [1:0] op, int slot, int x, int y,
                                        int w, int h, int layer, bit clip, int tag);
    hit_cmd_t c;
    c          = '0;
    c.op       = op;
    c.slot     = 6'(slot);
    c.pos_x    = 16'(x);
    c.pos_y    = 16'(y);
    c.size_w   = 15'(w);
    c.size_h   = 15'(h);
    c.layer_in = 16'(layer);
    c.clip_on  = clip;
    c.tag_in   = 8'(tag);
    return c;
  endfunction

  function automatic hit_cmd_t ptr_row(int x, int y, bit pr, bit hd, bit rl);
    hit_cmd_t c;
    c          = '0;
    c.op       = OP_POINTER;
    c.pos_x    = 16'(x);
    c.pos_y    = 16'(y);
    c.pressed  = pr;
    c.held     = hd;
    c.released = rl;
    return c;
  endfunction

  function automatic hit_cmd_t clear_cmd();
    hit_cmd_t c;
    c    = '0;
    c.op = OP_CLEAR;
    return c;
  endfunction

  // Mostly a small working set of slots so gestures find overlapping regions
  function automatic logic [5:0] pick_slot();
    return ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, 11));
  endfunction

  // Random geometry: mostly a small window around the origin, sometimes the
  // full coordinate range
  function automatic hit_cmd_t random_box(logic [1:0] op, logic [5:0] slot);
    hit_cmd_t c;
    c      = '0;
    c.op   = op;
    c.slot = slot;
    if ($urandom_range(0, 4) == 0) begin
      c.pos_x  = 16'($urandom);
      c.pos_y  = 16'($urandom);
      c.size_w = 15'($urandom);
      c.size_h = 15'($urandom);
    end else begin
      c.pos_x  = 16'($urandom_range(0, 400) - 200);
      c.pos_y  = 16'($urandom_range(0, 400) - 200);
      c.size_w = 15'($urandom_range(0, 300));
      c.size_h = 15'($urandom_range(0, 300));
    end
    // narrow layers make ties frequent
    c.layer_in = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6) - 3);
    c.tag_in   = 8'($urandom);
    return c;
  endfunction

  // Pointer aimed inside some live region (its clip when clipped), or a
  // stray point now and then. Flags are left for the caller.
  function automatic hit_cmd_t aim_pointer();
    hit_cmd_t c;
    rect_t    area;
    int       first, slot, bx, by, span_x, span_y;
    c       = '0;
    c.op    = OP_POINTER;
    c.pos_x = 16'($urandom);
    c.pos_y = 16'($urandom);
    if ($urandom_range(0, 9) == 0) return c;
    first = $urandom_range(0, REGIONS - 1);
    for (int k = 0; k < REGIONS; k++) begin
      slot = (first + k) % REGIONS;
      area = clip_en[slot] ? clip_of[slot] : box_of[slot];
      if (live[slot] && area.w != 0 && area.h != 0) begin
        bx     = $signed(area.x);
        by     = $signed(area.y);
        span_x = int'(area.w) - 1;
        span_y = int'(area.h) - 1;
        if (bx + span_x > 32767) span_x = 32767 - bx;
        if (by + span_y > 32767) span_y = 32767 - by;
        c.pos_x = 16'(bx + int'($urandom_range(0, span_x)));
        c.pos_y = 16'(by + int'($urandom_range(0, span_y)));
        return c;
      end
    end
    return c;
  endfunction

  // --------------------------------------------------------------------------
  // Driver: presents one transaction, waits for the handshake, records the
  // expected result. Called on a rising edge, returns on the accepting edge.
  // --------------------------------------------------------------------------
  task automatic send_item(hit_cmd_t c, want_src_t src = PREDICTED,
                           hit_outcome_t want = NO_OUTCOME);
    hit_outcome_t predicted;
    // random sender gaps, with a 35 percent chance of one more idle cycle
    if (!steady) begin
      while ($urandom_range(0, 99) < 35) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    in_op       <= c.op;
    in_slot     <= c.slot;
    in_pos_x    <= c.pos_x;
    in_pos_y    <= c.pos_y;
    in_size_w   <= c.size_w;
    in_size_h   <= c.size_h;
    in_layer_in <= c.layer_in;
    in_clip_on  <= c.clip_on;
    in_tag_in   <= c.tag_in;
    in_pressed  <= c.pressed;
    in_held     <= c.held;
    in_released <= c.released;
    start       <= 1'b1;
    do @(posedge clk); while (busy);
    predicted = predict_outcome(c);
    expected_outcomes.push_back(src == TYPED ? want : predicted);
    sent_items++;
  endtask

  // Hold off new transactions until every outstanding result has come back.
  // Always waits for a clock edge first so start never gets two updates in
  // one step.
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (expected_outcomes.size() != 0);
  endtask

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------
  task automatic report_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= 40) $display("ERROR @%0t: %s", $time, what);
  endtask

  task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s: got %0d, expected %0d", name, got, want));
  endtask

  // No backpressure: every out_valid cycle carries a result that must be
  // taken at the edge that ends it.
  always @(posedge clk) begin : result_check
    hit_outcome_t want;
    if (rst_n && out_valid) begin
      if (expected_outcomes.size() == 0) begin
        report_mismatch("result strobe with no transaction outstanding");
      end else begin
        want = expected_outcomes.pop_front();
        check_field("hit_valid",      8'(out_hit_valid),      8'(want.hit_valid));
        check_field("hit_slot",       8'(out_hit_slot),       8'(want.hit_slot));
        check_field("active_valid",   8'(out_active_valid),   8'(want.active_valid));
        check_field("active_slot",    8'(out_active_slot),    8'(want.active_slot));
        check_field("activated",      8'(out_activated),      8'(want.activated));
        check_field("activated_slot", 8'(out_activated_slot), 8'(want.activated_slot));
        check_field("activated_tag",  out_activated_tag,      want.activated_tag);
        if (out_hit_valid === 1'b1) hit_count++;
        if (out_activated === 1'b1) activation_count++;
      end
    end
  end

  // Watchdog: ends the run when neither side moves a transaction for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || out_valid === 1'b1) quiet = 0;
      else quiet++;
    end
    $display("ERROR @%0t: no transaction moved for %0d cycles", $time, STALL_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    script_row_t script[$];
    hit_cmd_t    item;
    hit_cmd_t    press_at;
    logic [5:0]  slot;
    int          pick, n, target;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table. Loads, clears and the extreme corners have results
    // that are plain to see; the rest go through the model.
    // Pointer into an empty table after reset
    script.push_back('{ptr_row(0, 0, 1, 1, 0), TYPED, NO_OUTCOME});
    // Most negative corner, lowest layer; covers x,y in [-32768, -2]
    script.push_back('{load_row(OP_LOAD_RECT, 0, -32768, -32768, 32767, 32767,
                                -32768, 0, 8'hFF), TYPED, NO_OUTCOME});
    // Clip first, then a big region limited to it
    script.push_back('{load_row(OP_LOAD_CLIP, 5, 100, 100, 50, 50, 0, 0, 0),
                       TYPED, NO_OUTCOME});
    script.push_back('{load_row(OP_LOAD_RECT, 5, 0, 0, 1000, 1000, 10, 1, 8'hA5),
                       TYPED, NO_OUTCOME});
    // Same box and layer in a higher slot: wins the tie
    script.push_back('{load_row(OP_LOAD_RECT, 7, 0, 0, 1000, 1000, 10, 0, 8'h3C),
                       TYPED, NO_OUTCOME});
    // Zero width on top of everything: never hit
    script.push_back('{load_row(OP_LOAD_RECT, 9, 0, 0, 0, 100, 32767, 0, 8'h11),
                       TYPED, NO_OUTCOME});
    // Most positive corner, highest layer, last slot
    script.push_back('{load_row(OP_LOAD_RECT, 63, 32767, 32767, 32767, 32767,
                                32767, 0, 8'h81), TYPED, NO_OUTCOME});
    script.push_back('{ptr_row(120, 120, 1, 1, 0), PREDICTED, NO_OUTCOME});
    script.push_back('{ptr_row(120, 120, 0, 1, 1), PREDICTED, NO_OUTCOME});
    script.push_back('{ptr_row(0, 0, 1, 1, 0), PREDICTED, NO_OUTCOME});
    // Drop slot 7 one layer so the clipped slot 5 wins inside its clip
    script.push_back('{load_row(OP_LOAD_RECT, 7, 0, 0, 1000, 1000, 9, 0, 8'h3C),
                       TYPED, NO_OUTCOME});
    script.push_back('{ptr_row(120, 120, 1, 1, 0), PREDICTED, NO_OUTCOME});
    // Drag off to another region while held, release there: no activation
    script.push_back('{ptr_row(500, 500, 0, 1, 0), PREDICTED, NO_OUTCOME});
    script.push_back('{ptr_row(500, 500, 0, 0, 1), PREDICTED, NO_OUTCOME});
    // Release with nothing latched
    script.push_back('{ptr_row(120, 120, 0, 0, 1), PREDICTED, NO_OUTCOME});
    // Press and release in one event at the top corner
    script.push_back('{ptr_row(32767, 32767, 1, 1, 1), TYPED,
                       '{1'b1, 6'd63, 1'b1, 6'd63, 1'b1, 6'd63, 8'h81}});
    // Bottom corner, press with hold, then an event with neither press nor hold
    script.push_back('{ptr_row(-32768, -32768, 1, 1, 0), PREDICTED, NO_OUTCOME});
    script.push_back('{ptr_row(-32768, -32768, 0, 0, 0), PREDICTED, NO_OUTCOME});
    // Just past the right edge of slot 0
    script.push_back('{ptr_row(-1, -1, 1, 1, 0), PREDICTED, NO_OUTCOME});
    script.push_back('{ptr_row(-2, -2, 1, 1, 0), PREDICTED, NO_OUTCOME});
    // Clear drops the latch and empties the table
    script.push_back('{clear_cmd(), TYPED, NO_OUTCOME});
    script.push_back('{ptr_row(120, 120, 0, 1, 1), TYPED, NO_OUTCOME});
    // Clip enable after a clear reuses the clip still held for slot 5
    script.push_back('{load_row(OP_LOAD_RECT, 5, 0, 0, 10, 10, 0, 1, 8'h5A),
                       TYPED, NO_OUTCOME});
    script.push_back('{ptr_row(5, 5, 1, 1, 0), PREDICTED, NO_OUTCOME});

    foreach (script[k]) send_item(script[k].cmd, script[k].src, script[k].want);
    drain_results();

    // Random part: gestures over a live table, loads, clears and noise
    target = sent_items + RANDOM_ITEMS;
    while (sent_items < target) begin
      // one long stretch with back-to-back transactions
      steady = (target - sent_items) < 400 && (target - sent_items) >= 250;
      pick   = $urandom_range(0, 99);
      if (pick < 50) begin
        // press, optional moves while held, then release
        item          = aim_pointer();
        item.pressed  = 1'b1;
        item.held     = ($urandom_range(0, 9) != 0);
        item.released = ($urandom_range(0, 9) == 0);
        send_item(item);
        press_at = item;
        n = $urandom_range(0, 3);
        repeat (n) begin
          item          = $urandom_range(0, 1) ? aim_pointer() : press_at;
          item.pressed  = ($urandom_range(0, 9) == 0);
          item.held     = 1'b1;
          item.released = 1'b0;
          send_item(item);
        end
        item          = ($urandom_range(0, 9) < 7) ? press_at : aim_pointer();
        item.pressed  = 1'b0;
        item.held     = ($urandom_range(0, 3) == 0);
        item.released = 1'b1;
        send_item(item);
      end else if (pick < 72) begin
        n = $urandom_range(1, 4);
        repeat (n) begin
          slot = pick_slot();
          if ($urandom_range(0, 2) == 0) begin
            send_item(random_box(OP_LOAD_CLIP, slot));
            item         = random_box(OP_LOAD_RECT, slot);
            item.clip_on = 1'b1;
          end else begin
            item         = random_box(OP_LOAD_RECT, slot);
            // a clip enable only where a clip has been written
            item.clip_on = clip_written[slot] && ($urandom_range(0, 3) == 0);
          end
          send_item(item);
        end
      end else if (pick < 96) begin
        // noise: any opcode, junk in the fields the opcode ignores
        item = random_box(2'($urandom), 6'($urandom));
        {item.pressed, item.held, item.released} = 3'($urandom);
        item.clip_on = (item.op != OP_LOAD_RECT || clip_written[item.slot]) ?
                       1'($urandom) : 1'b0;
        send_item(item);
      end else begin
        send_item(clear_cmd());
      end
      // now and then the sender waits for everything to come back
      if ($urandom_range(0, 19) == 0) drain_results();
    end

    steady = 1'b0;
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Run covered %0d transactions: %0d pointer events, %0d table clears.",
             sent_items, pointer_count, clear_count);
    $display("Pointer events over a region: %0d, activations reported: %0d.",
             hit_count, activation_count);
    if (mismatch_count == 0 && expected_outcomes.size() == 0) begin
      $display("No mismatches found");
    end else begin
      if (expected_outcomes.size() != 0)
        $display("ERROR: %0d results never arrived", expected_outcomes.size());
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
